// ===== hw/rtl/positional_array_list_top_assert.svh =====
// Assertion macros shared by the list block.
`ifndef POSITIONAL_ARRAY_LIST_TOP_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pal_pkg.sv =====
package pal_pkg;

    localparam int LEN_W  = 7;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_TRAVERSE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DELETE,
        CMD_CLEAR,
        CMD_EMPTY,
        CMD_EMIT
    } cmd_kind_t;

    typedef enum logic {
        S_IDLE,
        S_TRAV
    } state_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      last;
    } pal_cmd_t;

    typedef struct packed {
        logic             can_load;
        logic [LEN_W-1:0] count;
    } pal_stat_t;

endpackage

// ===== hw/rtl/pal_ctrl.sv =====
module pal_ctrl
    import pal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       operation,
    input  pal_stat_t        stat,
    output pal_cmd_t         cmd
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            accept;
    logic            trav_last;

    assign req_stall = !((state_reg == S_IDLE) && stat.can_load);
    assign accept    = req_valid && !req_stall;
    assign trav_last = ((LEN_W'(idx_reg) + LEN_W'(1)) == stat.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.kind   = CMD_NONE;
        cmd.last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(operation))
                        OP_INSERT: cmd.kind = CMD_INSERT;
                        OP_DELETE: cmd.kind = CMD_DELETE;
                        OP_CLEAR:  cmd.kind = CMD_CLEAR;
                        OP_TRAVERSE:
                        begin
                            if (stat.count == '0)
                            begin
                                cmd.kind = CMD_EMPTY;
                            end
                            else
                            begin
                                cmd.kind = CMD_EMIT;
                                cmd.last = (stat.count == LEN_W'(1));
                                if (stat.count != LEN_W'(1))
                                begin
                                    idx_next   = CW'(1);
                                    state_next = S_TRAV;
                                end
                            end
                        end
                        default: cmd.kind = CMD_NONE;
                    endcase
                end
            end
            S_TRAV:
            begin
                if (stat.can_load)
                begin
                    cmd.kind = CMD_EMIT;
                    cmd.last = trav_last;
                    idx_next = idx_reg + CW'(1);
                    if (trav_last)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `include "positional_array_list_top_assert.svh"

    `PAL_ASSERT_NOW(a_trav_idx_in_range, state_reg == S_TRAV,
        (LEN_W'(idx_reg) < stat.count) && (idx_reg != '0), "traverse index out of range")
    `PAL_ASSERT_NOW(a_trav_blocks_input, state_reg == S_TRAV, req_stall,
        "input taken during traverse")
    `PAL_ASSERT_NEXT(a_trav_ends_on_last,
        (state_reg == S_TRAV) && (cmd.kind == CMD_EMIT) && cmd.last,
        state_reg == S_IDLE, "traverse did not end after last beat")

endmodule

// ===== hw/rtl/pal_datapath.sv =====
module pal_datapath
    import pal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pal_cmd_t                 cmd,
    output pal_stat_t                stat,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] element,
    output logic [LEN_W-1:0]         length,
    output logic                     last
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] cells_reg [CAPACITY];
    logic signed [DATA_W-1:0] cells_next [CAPACITY];
    logic [CW-1:0]            count_reg, count_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic [LEN_W-1:0]         length_reg, length_next;
    logic                     last_reg, last_next;

    logic [LEN_W:0]   pos_w, cnt_w;
    logic [LEN_W-1:0] count7, ins_at, del_at, cnt_m1;
    logic             ins_bad, ins_full, ins_ok, del_bad, del_ok;

    assign count7   = LEN_W'(count_reg);
    assign pos_w    = (LEN_W + 1)'(position);
    assign cnt_w    = (LEN_W + 1)'(count_reg);
    assign ins_bad  = pos_w > (cnt_w + (LEN_W + 1)'(1));
    assign ins_full = (cnt_w == (LEN_W + 1)'(CAPACITY));
    assign ins_ok   = (cmd.kind == CMD_INSERT) && !ins_bad && !ins_full;
    assign del_bad  = (position == '0) || (pos_w > cnt_w);
    assign del_ok   = (cmd.kind == CMD_DELETE) && !del_bad;
    assign ins_at   = (position == '0) ? '0 : LEN_W'(position - POS_W'(1));
    assign del_at   = LEN_W'(position - POS_W'(1));
    assign cnt_m1   = count7 - LEN_W'(1);

    assign stat.can_load = !rsp_valid_reg || !rsp_stall;
    assign stat.count    = count7;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [LEN_W-1:0] IDX = LEN_W'(i);
        logic signed [DATA_W-1:0] prev_w, nxt_w;

        if (i == 0)
        begin : g_first
            assign prev_w = value;
        end
        else
        begin : g_prev
            assign prev_w = cells_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign nxt_w = cells_reg[i];
        end
        else
        begin : g_nxt
            assign nxt_w = cells_reg[i+1];
        end

        always_comb
        begin
            cells_next[i] = cells_reg[i];
            case (cmd.kind)
                CMD_INSERT:
                begin
                    if (ins_ok && (IDX == ins_at))
                    begin
                        cells_next[i] = value;
                    end
                    else if (ins_ok && (IDX > ins_at))
                    begin
                        cells_next[i] = prev_w;
                    end
                end
                CMD_DELETE:
                begin
                    if (del_ok && (IDX >= del_at))
                    begin
                        cells_next[i] = nxt_w;
                    end
                end
                CMD_EMIT:
                begin
                    if (IDX == cnt_m1)
                    begin
                        cells_next[i] = cells_reg[0];
                    end
                    else if (IDX < cnt_m1)
                    begin
                        cells_next[i] = nxt_w;
                    end
                end
                default: cells_next[i] = cells_reg[i];
            endcase
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        element_next   = element_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.kind == CMD_CLEAR)
        begin
            count_next = '0;
        end
        if (cmd.kind != CMD_NONE)
        begin
            rsp_valid_next = 1'b1;
            element_next   = '0;
            length_next    = LEN_W'(count_next);
            last_next      = cmd.last;
            case (cmd.kind)
                CMD_INSERT: status_next = ins_bad ? ST_BADPOS : (ins_full ? ST_FULL : ST_OK);
                CMD_DELETE: status_next = del_bad ? ST_BADPOS : ST_OK;
                CMD_EMPTY:  status_next = ST_EMPTY;
                CMD_EMIT:
                begin
                    status_next  = ST_OK;
                    element_next = cells_reg[0];
                end
                default:    status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg   <= cells_next;
        status_reg  <= status_next;
        element_reg <= element_next;
        length_reg  <= length_next;
        last_reg    <= last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign length    = length_reg;
    assign last      = last_reg;

    `include "positional_array_list_top_assert.svh"

    `PAL_ASSERT_NOW(a_count_bounded, 1'b1, cnt_w <= (LEN_W + 1)'(CAPACITY),
        "entry count above capacity")
    `PAL_ASSERT_NOW(a_no_load_over_stall, cmd.kind != CMD_NONE, stat.can_load,
        "result loaded over a held beat")
    `PAL_ASSERT_NEXT(a_full_means_full, ins_full && (cmd.kind == CMD_INSERT) && !ins_bad,
        (status_reg == ST_FULL) && (length_reg == LEN_W'(CAPACITY)),
        "full insert reported wrongly")

endmodule

// ===== hw/rtl/positional_array_list_top.sv =====
// Channel   Handshake             Fields
// request   req_valid/req_stall   operation[1:0] position[6:0] value[31:0]
// response  rsp_valid/rsp_stall   status[1:0] element[31:0] length[6:0] last
//
// Insert, delete and clear give one beat each; the cell chain shifts every
// entry at once. Traverse gives count beats, one per cycle unless stalled, by
// rotating the chain through cell 0, and takes no request until its last beat.
// A beat held by rsp_stall holds the request side too. rst_n empties the list.
module positional_array_list_top
    import pal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [1:0]               operation,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] element,
    output logic [LEN_W-1:0]         length,
    output logic                     last
);

    pal_cmd_t  cmd;
    pal_stat_t stat;

    pal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    pal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .position  (position),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .element   (element),
        .length    (length),
        .last      (last)
    );

endmodule
